### sv/ec2_pkg.sv
// widths, lane codes and word types shared by the collision response pipeline
// no dependencies
package ec2_pkg;

    localparam int POS_W  = 24;
    localparam int VEL_W  = 20;
    localparam int RAD_W  = 16;
    localparam int DEN_W  = 16;

    localparam int D_W    = POS_W + 1;
    localparam int DV_W   = VEL_W + 1;
    localparam int PR1_W  = D_W + DV_W;
    localparam int DOT_W  = PR1_W + 1;
    localparam int DOTM_W = PR1_W;
    localparam int DM_W   = D_W;
    localparam int N_W    = 2 * D_W;
    localparam int R2_W   = 2 * RAD_W;
    localparam int MASS_W = R2_W + DEN_W;
    localparam int SUM_W  = MASS_W + 1;

    localparam int MQ_W   = 18;
    localparam int F_W    = MQ_W;
    localparam int MR_W   = SUM_W + MQ_W;

    localparam int HALF_W = DOTM_W / 2;
    localparam int GP_W   = HALF_W + DM_W;
    localparam int G_W    = DOTM_W + DM_W - 1;

    localparam int CH_W   = 24;
    localparam int NCH    = 3;
    localparam int PP_W   = CH_W + F_W;
    localparam int PR_W   = G_W + F_W;
    localparam int FRAC   = 16;
    localparam int NQ_W   = PR_W - FRAC;

    localparam int CQ_W   = 23;
    localparam int CR_W   = N_W + CQ_W;
    localparam int SV_W   = CQ_W + 2;

    localparam int LANES  = 4;
    localparam int LN_AX  = 0;
    localparam int LN_AY  = 1;
    localparam int LN_BX  = 2;
    localparam int LN_BY  = 3;

    localparam logic [F_W-1:0] F_ONE = F_W'(1) << (F_W - 1);
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VEL_W-1:0] avx;
        logic signed [VEL_W-1:0] avy;
        logic signed [VEL_W-1:0] bvx;
        logic signed [VEL_W-1:0] bvy;
        logic                    sx;
        logic                    sy;
        logic                    ok;
        logic [N_W-1:0]          n;
    } t_side;

    typedef struct packed {
        t_side          s;
        logic [G_W-1:0] gx;
        logic [G_W-1:0] gy;
    } t_gside;

    typedef logic [LANES-1:0][NQ_W-1:0]  t_num4;
    typedef logic [LANES-1:0][VEL_W-1:0] t_vel4;

endpackage

### sv/elastic_collision_2d.sv
// path: front, mass divider, scale and change divider pipelines, then the output register
// throughput: one pair per cycle if o_ready; restoring dividers, one quotient bit per stage
// stall: a skid word behind the output register lets one more word in while output waits
// reset: synchronous active low, clears all valid bits; no clearing pass is needed
// top level, holds the output register and skid word; depends on ec2_pkg and all ec2 modules
module elastic_collision_2d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_a_pos_x,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_a_pos_y,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_a_vel_x,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_a_vel_y,
    input  logic        [ec2_pkg::RAD_W-1:0]   i_a_radius,
    input  logic        [ec2_pkg::DEN_W-1:0]   i_a_density,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_b_pos_x,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_b_pos_y,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_b_vel_x,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_b_vel_y,
    input  logic        [ec2_pkg::RAD_W-1:0]   i_b_radius,
    input  logic        [ec2_pkg::DEN_W-1:0]   i_b_density,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ec2_pkg::VEL_W-1:0]   o_a_new_vel_x,
    output logic signed [ec2_pkg::VEL_W-1:0]   o_a_new_vel_y,
    output logic signed [ec2_pkg::VEL_W-1:0]   o_b_new_vel_x,
    output logic signed [ec2_pkg::VEL_W-1:0]   o_b_new_vel_y,
    output logic                               o_applied
);
    import ec2_pkg::*;

    logic              en;
    logic              fr_v, md_v, sc_v, cd_v;
    t_gside            fr_side, md_side;
    logic [MASS_W-1:0] fr_mb;
    logic [SUM_W-1:0]  fr_sum;
    logic [F_W-1:0]    md_fa, md_fb;
    t_side             sc_side;
    t_num4             sc_num;
    t_vel4             cd_vel;
    logic              cd_app;

    logic              r_ov, r_sv;
    t_vel4             r_ovel, r_svel;
    logic              r_oapp, r_sapp;

    assign en      = !r_sv;
    assign o_ready = en;

    ec2_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_a_pos_x   (i_a_pos_x),
        .i_a_pos_y   (i_a_pos_y),
        .i_a_vel_x   (i_a_vel_x),
        .i_a_vel_y   (i_a_vel_y),
        .i_a_radius  (i_a_radius),
        .i_a_density (i_a_density),
        .i_b_pos_x   (i_b_pos_x),
        .i_b_pos_y   (i_b_pos_y),
        .i_b_vel_x   (i_b_vel_x),
        .i_b_vel_y   (i_b_vel_y),
        .i_b_radius  (i_b_radius),
        .i_b_density (i_b_density),
        .o_valid     (fr_v),
        .o_side      (fr_side),
        .o_mb        (fr_mb),
        .o_sum       (fr_sum)
    );

    ec2_mass_div u_mass_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_v),
        .i_side  (fr_side),
        .i_mb    (fr_mb),
        .i_sum   (fr_sum),
        .o_valid (md_v),
        .o_side  (md_side),
        .o_fa    (md_fa),
        .o_fb    (md_fb)
    );

    ec2_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (md_v),
        .i_side  (md_side),
        .i_fa    (md_fa),
        .i_fb    (md_fb),
        .o_valid (sc_v),
        .o_side  (sc_side),
        .o_num   (sc_num)
    );

    ec2_chg_div u_chg_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (sc_v),
        .i_side    (sc_side),
        .i_num     (sc_num),
        .o_valid   (cd_v),
        .o_vel     (cd_vel),
        .o_applied (cd_app)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_ready) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (cd_v) begin
            if (!r_ov || i_ready) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_ready) begin
                r_ovel <= r_svel;
                r_oapp <= r_sapp;
            end
        end else if (cd_v) begin
            if (!r_ov || i_ready) begin
                r_ovel <= cd_vel;
                r_oapp <= cd_app;
            end else begin
                r_svel <= cd_vel;
                r_sapp <= cd_app;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_a_new_vel_x = r_ovel[LN_AX];
    assign o_a_new_vel_y = r_ovel[LN_AY];
    assign o_b_new_vel_x = r_ovel[LN_BX];
    assign o_b_new_vel_y = r_ovel[LN_BY];
    assign o_applied     = r_oapp;

endmodule

### sv/ec2_front.sv
// front stages: differences, dot product, squared distance, masses, dot times offsets
// depends on ec2_pkg
module ec2_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_a_pos_x,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_a_pos_y,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_a_vel_x,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_a_vel_y,
    input  logic        [ec2_pkg::RAD_W-1:0]   i_a_radius,
    input  logic        [ec2_pkg::DEN_W-1:0]   i_a_density,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_b_pos_x,
    input  logic signed [ec2_pkg::POS_W-1:0]   i_b_pos_y,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_b_vel_x,
    input  logic signed [ec2_pkg::VEL_W-1:0]   i_b_vel_y,
    input  logic        [ec2_pkg::RAD_W-1:0]   i_b_radius,
    input  logic        [ec2_pkg::DEN_W-1:0]   i_b_density,
    output logic                               o_valid,
    output ec2_pkg::t_gside                    o_side,
    output logic        [ec2_pkg::MASS_W-1:0]  o_mb,
    output logic        [ec2_pkg::SUM_W-1:0]   o_sum
);
    import ec2_pkg::*;

    logic [5:0] r_vld;

    logic signed [D_W-1:0]   r1_dx, r1_dy;
    logic signed [DV_W-1:0]  r1_dvx, r1_dvy;
    logic [R2_W-1:0]         r1_ar2, r1_br2;
    logic [DEN_W-1:0]        r1_ad, r1_bd;
    logic signed [VEL_W-1:0] r1_avx, r1_avy, r1_bvx, r1_bvy;

    logic signed [PR1_W-1:0] r2_px, r2_py;
    logic [N_W-1:0]          r2_nx, r2_ny;
    logic [MASS_W-1:0]       r2_ma, r2_mb;
    logic signed [D_W-1:0]   r2_dx, r2_dy;
    logic signed [VEL_W-1:0] r2_avx, r2_avy, r2_bvx, r2_bvy;

    logic signed [DOT_W-1:0] r3_dot;
    logic [N_W-1:0]          r3_n;
    logic [SUM_W-1:0]        r3_sum;
    logic [MASS_W-1:0]       r3_mb;
    logic signed [D_W-1:0]   r3_dx, r3_dy;
    logic signed [VEL_W-1:0] r3_avx, r3_avy, r3_bvx, r3_bvy;

    logic [DOTM_W-1:0]       r4_dotm;
    logic [DM_W-1:0]         r4_dxm, r4_dym;
    t_side                   r4_s;
    logic [SUM_W-1:0]        r4_sum;
    logic [MASS_W-1:0]       r4_mb;

    logic [GP_W-1:0]         r5_gxl, r5_gxh, r5_gyl, r5_gyh;
    t_side                   r5_s;
    logic [SUM_W-1:0]        r5_sum;
    logic [MASS_W-1:0]       r5_mb;

    t_gside                  r6_side;
    logic [SUM_W-1:0]        r6_sum;
    logic [MASS_W-1:0]       r6_mb;

    logic signed [N_W-1:0]   sqx, sqy;
    logic signed [DOT_W-1:0] ndot;
    logic signed [D_W-1:0]   ndx, ndy;

    assign sqx  = r1_dx * r1_dx;
    assign sqy  = r1_dy * r1_dy;
    assign ndot = -r3_dot;
    assign ndx  = -r3_dx;
    assign ndy  = -r3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= D_W'(i_a_pos_x) - D_W'(i_b_pos_x);
            r1_dy  <= D_W'(i_a_pos_y) - D_W'(i_b_pos_y);
            r1_dvx <= DV_W'(i_a_vel_x) - DV_W'(i_b_vel_x);
            r1_dvy <= DV_W'(i_a_vel_y) - DV_W'(i_b_vel_y);
            r1_ar2 <= i_a_radius * i_a_radius;
            r1_br2 <= i_b_radius * i_b_radius;
            r1_ad  <= i_a_density;
            r1_bd  <= i_b_density;
            r1_avx <= i_a_vel_x;
            r1_avy <= i_a_vel_y;
            r1_bvx <= i_b_vel_x;
            r1_bvy <= i_b_vel_y;

            r2_px  <= r1_dx * r1_dvx;
            r2_py  <= r1_dy * r1_dvy;
            r2_nx  <= unsigned'(sqx);
            r2_ny  <= unsigned'(sqy);
            r2_ma  <= r1_ad * r1_ar2;
            r2_mb  <= r1_bd * r1_br2;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_avx <= r1_avx;
            r2_avy <= r1_avy;
            r2_bvx <= r1_bvx;
            r2_bvy <= r1_bvy;

            r3_dot <= DOT_W'(r2_px) + DOT_W'(r2_py);
            r3_n   <= r2_nx + r2_ny;
            r3_sum <= SUM_W'(r2_ma) + SUM_W'(r2_mb);
            r3_mb  <= r2_mb;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_avx <= r2_avx;
            r3_avy <= r2_avy;
            r3_bvx <= r2_bvx;
            r3_bvy <= r2_bvy;

            r4_dotm  <= r3_dot[DOT_W-1] ? DOTM_W'(ndot) : DOTM_W'(r3_dot);
            r4_dxm   <= r3_dx[D_W-1] ? unsigned'(ndx) : unsigned'(r3_dx);
            r4_dym   <= r3_dy[D_W-1] ? unsigned'(ndy) : unsigned'(r3_dy);
            r4_s.avx <= r3_avx;
            r4_s.avy <= r3_avy;
            r4_s.bvx <= r3_bvx;
            r4_s.bvy <= r3_bvy;
            r4_s.sx  <= r3_dot[DOT_W-1] ^ r3_dx[D_W-1];
            r4_s.sy  <= r3_dot[DOT_W-1] ^ r3_dy[D_W-1];
            r4_s.ok  <= (r3_dot[DOT_W-1] || (r3_dot == '0)) && (r3_n != '0)
                        && (r3_sum != '0);
            r4_s.n   <= r3_n;
            r4_sum   <= r3_sum;
            r4_mb    <= r3_mb;

            r5_gxl <= r4_dotm[HALF_W-1:0] * r4_dxm;
            r5_gxh <= r4_dotm[DOTM_W-1:HALF_W] * r4_dxm;
            r5_gyl <= r4_dotm[HALF_W-1:0] * r4_dym;
            r5_gyh <= r4_dotm[DOTM_W-1:HALF_W] * r4_dym;
            r5_s   <= r4_s;
            r5_sum <= r4_sum;
            r5_mb  <= r4_mb;

            r6_side.s  <= r5_s;
            r6_side.gx <= (G_W'(r5_gxh) << HALF_W) + G_W'(r5_gxl);
            r6_side.gy <= (G_W'(r5_gyh) << HALF_W) + G_W'(r5_gyl);
            r6_sum     <= r5_sum;
            r6_mb      <= r5_mb;
        end
    end

    assign o_valid = r_vld[5];
    assign o_side  = r6_side;
    assign o_sum   = r6_sum;
    assign o_mb    = r6_mb;

endmodule

### sv/ec2_mass_div.sv
// pipelined restoring divider for the mass factors, one quotient bit per stage
// depends on ec2_pkg
module ec2_mass_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  ec2_pkg::t_gside                   i_side,
    input  logic        [ec2_pkg::MASS_W-1:0] i_mb,
    input  logic        [ec2_pkg::SUM_W-1:0]  i_sum,
    output logic                              o_valid,
    output ec2_pkg::t_gside                   o_side,
    output logic        [ec2_pkg::F_W-1:0]    o_fa,
    output logic        [ec2_pkg::F_W-1:0]    o_fb
);
    import ec2_pkg::*;

    logic [MQ_W:0]     r_vld;
    logic [MR_W-1:0]   r_rem  [MQ_W];
    logic [SUM_W-1:0]  r_sum  [MQ_W];
    logic [MQ_W-1:0]   r_q    [MQ_W];
    t_gside            r_side [MQ_W+1];
    logic [F_W-1:0]    r_fa, r_fb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MQ_W-1:0], i_valid};
        end
    end

    for (genvar k = 0; k < MQ_W; k++) begin : g_stage
        logic [MR_W-1:0]  rem_in, dsh, diff;
        logic [SUM_W-1:0] sum_in;
        logic [MQ_W-1:0]  q_in;
        t_gside           side_in;
        logic             ge;

        if (k == 0) begin : g_head
            assign rem_in  = MR_W'({i_mb, {(MQ_W-1){1'b0}}});
            assign sum_in  = i_sum;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_body
            assign rem_in  = r_rem[k-1];
            assign sum_in  = r_sum[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign dsh  = MR_W'(sum_in) << (MQ_W - 1 - k);
        assign ge   = rem_in >= dsh;
        assign diff = rem_in - dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff : rem_in;
                r_sum[k]  <= sum_in;
                r_q[k]    <= {q_in[MQ_W-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    // other factor from the remainder: 2^17 - ceil(2^17 mb / sum)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fa         <= r_q[MQ_W-1];
            r_fb         <= F_ONE - r_q[MQ_W-1] - F_W'(r_rem[MQ_W-1] != '0);
            r_side[MQ_W] <= r_side[MQ_W-1];
        end
    end

    assign o_valid = r_vld[MQ_W];
    assign o_side  = r_side[MQ_W];
    assign o_fa    = r_fa;
    assign o_fb    = r_fb;

endmodule

### sv/ec2_scale.sv
// mass factor times dot-offset products, split into partial products over two stages
// depends on ec2_pkg
module ec2_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  ec2_pkg::t_gside                i_side,
    input  logic        [ec2_pkg::F_W-1:0] i_fa,
    input  logic        [ec2_pkg::F_W-1:0] i_fb,
    output logic                           o_valid,
    output ec2_pkg::t_side                 o_side,
    output ec2_pkg::t_num4                 o_num
);
    import ec2_pkg::*;

    logic [1:0]                                 r_vld;
    logic [LANES-1:0][NCH-1:0][PP_W-1:0]        r_pp;
    t_side                                      r_sa, r_sb;
    t_num4                                      r_num;

    logic [LANES-1:0][NCH*CH_W-1:0]             g_l;
    logic [LANES-1:0][F_W-1:0]                  f_l;
    logic [LANES-1:0][PR_W-1:0]                 full;

    assign g_l[LN_AX] = (NCH*CH_W)'(i_side.gx);
    assign g_l[LN_AY] = (NCH*CH_W)'(i_side.gy);
    assign g_l[LN_BX] = (NCH*CH_W)'(i_side.gx);
    assign g_l[LN_BY] = (NCH*CH_W)'(i_side.gy);
    assign f_l[LN_AX] = i_fa;
    assign f_l[LN_AY] = i_fa;
    assign f_l[LN_BX] = i_fb;
    assign f_l[LN_BY] = i_fb;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            full[l] = '0;
            for (int c = 0; c < NCH; c++) begin
                full[l] = full[l] + (PR_W'(r_pp[l][c]) << (c * CH_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < NCH; c++) begin
                    r_pp[l][c] <= g_l[l][c*CH_W +: CH_W] * f_l[l];
                end
                r_num[l] <= full[l][PR_W-1:FRAC];
            end
            r_sa <= i_side.s;
            r_sb <= r_sa;
        end
    end

    assign o_valid = r_vld[1];
    assign o_side  = r_sb;
    assign o_num   = r_num;

endmodule

### sv/ec2_chg_div.sv
// four-lane pipelined divider by squared distance, then velocity update and saturation
// depends on ec2_pkg
module ec2_chg_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ec2_pkg::t_side  i_side,
    input  ec2_pkg::t_num4  i_num,
    output logic            o_valid,
    output ec2_pkg::t_vel4  o_vel,
    output logic            o_applied
);
    import ec2_pkg::*;

    logic [CQ_W:0]                   r_vld;
    logic [LANES-1:0][CR_W-1:0]      r_rem  [CQ_W];
    logic [LANES-1:0][CQ_W-1:0]      r_q    [CQ_W];
    t_side                           r_side [CQ_W];
    t_vel4                           r_vel;
    logic                            r_app;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CQ_W-1:0], i_valid};
        end
    end

    for (genvar k = 0; k < CQ_W; k++) begin : g_stage
        logic [LANES-1:0][CR_W-1:0] rem_in, rem_nx;
        logic [LANES-1:0][CQ_W-1:0] q_in, q_nx;
        logic [LANES-1:0]           ge;
        logic [CR_W-1:0]            dsh;
        t_side                      side_in;

        if (k == 0) begin : g_head
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = CR_W'(i_num[l]);
            end
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_body
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        assign dsh = CR_W'(side_in.n) << (CQ_W - 1 - k);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                ge[l]     = rem_in[l] >= dsh;
                rem_nx[l] = ge[l] ? rem_in[l] - dsh : rem_in[l];
                q_nx[l]   = {q_in[l][CQ_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= rem_nx;
                r_q[k]    <= q_nx;
                r_side[k] <= side_in;
            end
        end
    end

    t_side                          fs;
    logic [LANES-1:0][VEL_W-1:0]    vin;
    logic [LANES-1:0]               add_q;
    logic signed [SV_W-1:0]         vext  [LANES];
    logic signed [SV_W-1:0]         qext  [LANES];
    logic signed [SV_W-1:0]         res   [LANES];
    t_vel4                          sat;

    assign fs         = r_side[CQ_W-1];
    assign vin[LN_AX] = fs.avx;
    assign vin[LN_AY] = fs.avy;
    assign vin[LN_BX] = fs.bvx;
    assign vin[LN_BY] = fs.bvy;
    // a moves against the signed change, b along it
    assign add_q[LN_AX] = fs.sx;
    assign add_q[LN_AY] = fs.sy;
    assign add_q[LN_BX] = !fs.sx;
    assign add_q[LN_BY] = !fs.sy;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            vext[l] = signed'({{(SV_W-VEL_W){vin[l][VEL_W-1]}}, vin[l]});
            qext[l] = signed'({{(SV_W-CQ_W){1'b0}}, r_q[CQ_W-1][l]});
            res[l]  = add_q[l] ? vext[l] + qext[l] : vext[l] - qext[l];
            if (res[l] > SV_W'(VEL_MAX)) begin
                sat[l] = VEL_MAX;
            end else if (res[l] < SV_W'(VEL_MIN)) begin
                sat[l] = VEL_MIN;
            end else begin
                sat[l] = res[l][VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vel <= fs.ok ? sat : vin;
            r_app <= fs.ok;
        end
    end

    assign o_valid   = r_vld[CQ_W];
    assign o_vel     = r_vel;
    assign o_applied = r_app;

endmodule

### verif/testbench.sv
// self-checking testbench for elastic_collision_2d: directed and random disc pairs,
// expected velocities computed by an exact integer collision model in the testbench
// depends on ec2_pkg and the elastic_collision_2d rtl
module testbench;
    import ec2_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0] apx, apy, bpx, bpy;
        logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
        logic [RAD_W-1:0]        ar, br;
        logic [DEN_W-1:0]        ad, bd;
    } t_pair;

    typedef struct {
        logic signed [VEL_W-1:0] ax, ay, bx, by;
        logic                    applied;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_applied;
    logic signed [POS_W-1:0] i_a_pos_x = '0, i_a_pos_y = '0, i_b_pos_x = '0, i_b_pos_y = '0;
    logic signed [VEL_W-1:0] i_a_vel_x = '0, i_a_vel_y = '0, i_b_vel_x = '0, i_b_vel_y = '0;
    logic [RAD_W-1:0] i_a_radius = '0, i_b_radius = '0;
    logic [DEN_W-1:0] i_a_density = '0, i_b_density = '0;
    logic signed [VEL_W-1:0] o_a_new_vel_x, o_a_new_vel_y, o_b_new_vel_x, o_b_new_vel_y;

    t_resp  expected_resp[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     hold_rx = 1'b0;
    bit     rx_random = 1'b1;

    elastic_collision_2d u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // exact collision response
    function automatic logic signed [VEL_W-1:0] sat_vel(logic signed [127:0] v);
        if (v > 128'sd524287) return VEL_MAX;
        if (v < -128'sd524288) return VEL_MIN;
        return v[VEL_W-1:0];
    endfunction

    function automatic logic [127:0] mass_ratio(logic [127:0] m_other, logic [127:0] total);
        return ((m_other << 1) << 16) / total;
    endfunction

    function automatic logic signed [127:0] delta_v(logic [127:0] f, logic signed [127:0] dot,
                                                    logic signed [127:0] dc, logic [127:0] n);
        logic [127:0] q;
        logic [127:0] dm, cm;
        dm = dot < 0 ? -dot : dot;
        cm = dc < 0 ? -dc : dc;
        q = (f * dm * cm) / n;
        if (q > (128'd1 << 62)) q = 128'd1 << 62;
        q = q >> 16;
        if (q > (128'd1 << 24)) q = 128'd1 << 24;
        return ((dot < 0) != (dc < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_resp collide(t_pair p);
        logic signed [127:0] dx, dy, dot;
        logic [127:0] n, ma, mb, total, fa, fb;
        t_resp r;
        dx = 128'(p.apx) - 128'(p.bpx);
        dy = 128'(p.apy) - 128'(p.bpy);
        dot = dx * (128'(p.avx) - 128'(p.bvx)) + dy * (128'(p.avy) - 128'(p.bvy));
        n = dx * dx + dy * dy;
        ma = 128'(p.ad) * p.ar * p.ar;
        mb = 128'(p.bd) * p.br * p.br;
        total = ma + mb;
        r = '{p.avx, p.avy, p.bvx, p.bvy, 1'b0};
        if (dot <= 0 && n != 0 && total != 0) begin
            fa = mass_ratio(mb, total);
            fb = mass_ratio(ma, total);
            r.ax = sat_vel(128'(p.avx) - delta_v(fa, dot, dx, n));
            r.ay = sat_vel(128'(p.avy) - delta_v(fa, dot, dy, n));
            r.bx = sat_vel(128'(p.bvx) + delta_v(fb, dot, dx, n));
            r.by = sat_vel(128'(p.bvy) + delta_v(fb, dot, dy, n));
            r.applied = 1'b1;
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic send_pair(t_pair p, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_a_pos_x   <= p.apx; i_a_pos_y <= p.apy; i_a_vel_x <= p.avx; i_a_vel_y <= p.avy;
        i_a_radius  <= p.ar;  i_a_density <= p.ad;
        i_b_pos_x   <= p.bpx; i_b_pos_y <= p.bpy; i_b_vel_x <= p.bvx; i_b_vel_y <= p.bvy;
        i_b_radius  <= p.br;  i_b_density <= p.bd;
        do @(posedge i_clk); while (!o_ready);
        expected_resp.push_back(collide(p));
    endtask

    // receiver side
    always @(posedge i_clk) begin
        t_resp w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_resp.size() == 0) begin
                $display("mismatch: unexpected word");
                errors++;
            end else begin
                w = expected_resp.pop_front();
                if (o_a_new_vel_x !== w.ax) report("a_new_vel_x", o_a_new_vel_x, w.ax);
                if (o_a_new_vel_y !== w.ay) report("a_new_vel_y", o_a_new_vel_y, w.ay);
                if (o_b_new_vel_x !== w.bx) report("b_new_vel_x", o_b_new_vel_x, w.bx);
                if (o_b_new_vel_y !== w.by) report("b_new_vel_y", o_b_new_vel_y, w.by);
                if (o_applied !== w.applied) report("applied", o_applied, w.applied);
            end
        end
    end

    always @(posedge i_clk) begin : rx_ready_gen
        int wait_left;
        if (hold_rx) begin
            i_ready <= 1'b0;
        end else if (!rx_random) begin
            i_ready <= 1'b1;
        end else if (wait_left > 0) begin
            wait_left--;
            i_ready <= (wait_left == 0);
        end else if (o_valid && i_ready) begin
            wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            i_ready <= (wait_left == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("** elastic_collision_2d: FAILED **");
            $finish;
        end
    end

    function automatic t_pair random_pair();
        t_pair p;
        int sh;
        sh = $urandom_range(0, 3);
        p.apx = POS_W'($urandom()); p.apy = POS_W'($urandom());
        p.bpx = POS_W'($urandom()); p.bpy = POS_W'($urandom());
        p.avx = VEL_W'($urandom()); p.avy = VEL_W'($urandom());
        p.bvx = VEL_W'($urandom()); p.bvy = VEL_W'($urandom());
        p.ar = RAD_W'($urandom()); p.br = RAD_W'($urandom());
        p.ad = DEN_W'($urandom()); p.bd = DEN_W'($urandom());
        if (sh == 1) begin
            // close discs with modest speeds
            p.bpx = p.apx + POS_W'($signed(16'($urandom())));
            p.bpy = p.apy + POS_W'($signed(16'($urandom())));
            p.avx = VEL_W'($signed(14'($urandom()))); p.avy = VEL_W'($signed(14'($urandom())));
            p.bvx = VEL_W'($signed(14'($urandom()))); p.bvy = VEL_W'($signed(14'($urandom())));
        end else if (sh == 2) begin
            p.bpx = p.apx + POS_W'($signed(6'($urandom())));
            p.bpy = p.apy + POS_W'($signed(6'($urandom())));
            if ($urandom_range(0, 3) == 0) p.ad = '0;
            if ($urandom_range(0, 3) == 0) p.br = '0;
        end
        return p;
    endfunction

    task automatic test_directed();
        t_pair p;
        p = '{0, 0, 256, 0, 256, 0, -256, 0, 256, 256, 256, 256};
        send_pair(p);                              // head-on equal masses
        p.avx = -256; p.bvx = 256; send_pair(p);   // separating
        p.bpx = 0; send_pair(p);                   // coincident centres
        p = '{0, 0, 256, 0, 0, 256, 0, 256, 0, 0, 0, 0};
        send_pair(p);                              // zero mass
        p.ar = 256; p.ad = 256; p.br = 256; p.bd = 256;
        send_pair(p);                              // dot exactly zero
        p = '{24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff,
              VEL_MIN, VEL_MAX, VEL_MAX, VEL_MIN, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
        send_pair(p);                              // extremes
        p = '{0, 0, 1, 1, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN,
              16'hffff, 1, 16'hffff, 1};
        send_pair(p);                              // saturation, lopsided masses
        p = '{1, 0, 0, 0, VEL_MIN, 0, VEL_MAX, 0, 1, 16'hffff, 1, 16'hffff};
        send_pair(p);
        p = '{-1, -1, 0, 0, -1, -1, 0, 0, 16'hffff, 0, 0, 16'hffff};
        send_pair(p);                              // zero mass both ways
        p = '{0, 0, 16'sh100, 0, 0, 0, 0, 1, 0, 0, 16'hffff, 16'h0001};
        send_pair(p);
    endtask

    task automatic test_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_back_to_back(int count);
        rx_random = 1'b0;
        repeat (count) send_pair(random_pair(), 1);
        rx_random = 1'b1;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            repeat (150) send_pair(random_pair(), 1);
        join
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(800);
        test_back_to_back(200);
        test_backpressure();
        test_random(50);
        i_valid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("** elastic_collision_2d: PASSED **");
        end else begin
            $display("** elastic_collision_2d: FAILED **");
        end
        $finish;
    end
endmodule
